### hw/rtl/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Shared constants, types and lookup tables of the privileged instruction
// filter: class test codes, BRK encoding and the system and base ROMs.
// ----------------------------------------------------------------------------
package pif_pkg;

    localparam int SYS_DEPTH     = 1024;
    localparam int BASE_DEPTH    = 256;
    localparam int SYS_IDX_W     = $clog2(SYS_DEPTH);
    localparam int BASE_IDX_W    = $clog2(BASE_DEPTH);
    localparam int COUNT_W       = 48;
    localparam int COUNT_OUT_W   = 48;
    localparam int SYS_ENTRY_W   = 28;
    localparam int BASE_ENTRY_W  = 54;
    localparam int SYS_SHIFT_LEN = 5;

    localparam logic [9:0]  SYS_CLASS   = 10'd852;
    localparam logic [10:0] BRK_OPC     = 11'h6A1;
    localparam logic [3:0]  TRAP_TAG    = 4'b0001;
    localparam logic [15:0] FILTER_IMM  = 16'h1FFF;
    localparam logic [10:0] BASE_FIXED  = 11'h7FF;

    localparam logic [1:0] ACT_KEEP   = 2'd0;
    localparam logic [1:0] ACT_TRAP   = 2'd1;
    localparam logic [1:0] ACT_FILTER = 2'd2;

    typedef struct packed {
        logic        is_system;
        logic [1:0]  action;
        logic [31:0] replacement;
    } t_decode;

    // bit 0 trap flag, bits [27:1] instruction[31:5], zero means empty
    function automatic logic [SYS_ENTRY_W-1:0] sys_rom(input logic [SYS_IDX_W-1:0] idx);
        logic [SYS_ENTRY_W-1:0] e;
        case (idx)
            10'd70:  e = 28'd223393762;
            10'd78:  e = 28'd223393746;
            10'd86:  e = 28'd223393730;
            10'd94:  e = 28'd223393714;
            10'd102: e = 28'd223393698;
            10'd142: e = 28'd223393618;
            10'd150: e = 28'd223393602;
            10'd395: e = 28'd223458338;
            10'd396: e = 28'd223458336;
            10'd403: e = 28'd223458370;
            10'd404: e = 28'd223458368;
            10'd414: e = 28'd223458348;
            10'd416: e = 28'd223458344;
            10'd420: e = 28'd223458336;
            10'd443: e = 28'd223460612;
            10'd838: e = 28'd223576181;
            10'd839: e = 28'd223576179;
            10'd840: e = 28'd223576177;
            10'd846: e = 28'd223576165;
            10'd847: e = 28'd223576163;
            10'd848: e = 28'd223576161;
            10'd851: e = 28'd223576155;
            10'd852: e = 28'd223576153;
            10'd855: e = 28'd223576147;
            10'd856: e = 28'd223576145;
            10'd863: e = 28'd223576131;
            10'd864: e = 28'd223576129;
            10'd890: e = 28'd223576077;
            10'd891: e = 28'd223576075;
            10'd896: e = 28'd223576065;
            10'd907: e = 28'd223589410;
            10'd908: e = 28'd223589408;
            10'd915: e = 28'd223589442;
            10'd916: e = 28'd223589440;
            10'd926: e = 28'd223589420;
            10'd928: e = 28'd223589416;
            10'd932: e = 28'd223589408;
            10'd937: e = 28'd223588366;
            10'd943: e = 28'd223588355;
            10'd952: e = 28'd223591948;
            10'd954: e = 28'd223591686;
            10'd955: e = 28'd223591684;
            10'd956: e = 28'd223591940;
            10'd958: e = 28'd223591936;
            default: e = '0;
        endcase
        return e;
    endfunction

    // bit 0 trap flag, bits [32:1] pattern, bits [53:33] extra mask bits
    function automatic logic [BASE_ENTRY_W-1:0] base_rom(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_ENTRY_W-1:0] e;
        logic [BASE_ENTRY_W-1:0] off;
        // hlt / hvc / smc groups: bits[7:5] step by 64, bit 13 steps by 16384
        off = BASE_ENTRY_W'({idx[5], 14'd0}) | BASE_ENTRY_W'({idx[4:2], 6'd0});
        case (idx)
            8'd67:  e = 54'd17981411717840958;
            8'd71:  e = 54'd17981411717841022;
            8'd75:  e = 54'd17981411717841086;
            8'd79:  e = 54'd17981411717841150;
            8'd83:  e = 54'd17981411717841214;
            8'd87:  e = 54'd17981411717841278;
            8'd91:  e = 54'd17981411718234558;
            8'd95:  e = 54'd17981411718234622;
            8'd111: e = 54'd18014397067051263;
            8'd156: e = 54'd18014397121038272;
            8'd159: e = 54'd18014397121189886;
            default: begin
                if (idx[7:6] == 2'b00) begin
                    case (idx[1:0])
                        2'd0:    e = 54'd72566299426816 + off;
                        2'd2:    e = 54'd72566291038212 + off;
                        2'd3:    e = 54'd72566291038214 + off;
                        default: e = '0;
                    endcase
                end else begin
                    e = '0;
                end
            end
        endcase
        return e;
    endfunction

    function automatic logic [31:0] brk_word(input logic [15:0] imm16);
        return {BRK_OPC, imm16, 5'd0};
    endfunction

endpackage

### hw/rtl/pif_decode.sv
// ----------------------------------------------------------------------------
// pif_decode
// Classifies one instruction word, looks it up in the system or base ROM
// and forms the action and replacement word.
// ----------------------------------------------------------------------------
module pif_decode (
    input  logic [31:0]      i_instruction,
    output pif_pkg::t_decode o_dec
);

    logic                                is_sys;
    logic [pif_pkg::SYS_IDX_W:0]         sys_diff;
    logic [pif_pkg::SYS_ENTRY_W-1:0]     sys_e;
    logic [pif_pkg::BASE_IDX_W-1:0]      base_idx;
    logic [pif_pkg::BASE_ENTRY_W-1:0]    base_e;
    logic [31:0]                         base_mask;
    logic                                sys_hit;
    logic                                base_hit;
    logic [1:0]                          action;

    assign is_sys = (i_instruction[31:22] == pif_pkg::SYS_CLASS)
                 && ((i_instruction[20:19] == 2'b01) || i_instruction[20]);

    // signed difference, top bit set means a negative index
    assign sys_diff = {1'b0, i_instruction[21:12]} - {4'd0, i_instruction[11:5]};
    assign sys_e    = pif_pkg::sys_rom(sys_diff[pif_pkg::SYS_IDX_W-1:0]);
    assign sys_hit  = !sys_diff[pif_pkg::SYS_IDX_W] && (sys_e != '0)
                   && (i_instruction[31:pif_pkg::SYS_SHIFT_LEN] == sys_e[27:1]);

    assign base_idx  = {i_instruction[25:24], i_instruction[13],
                        i_instruction[7:5], i_instruction[1:0]};
    assign base_e    = pif_pkg::base_rom(base_idx);
    assign base_mask = {pif_pkg::BASE_FIXED, base_e[53:33]};
    assign base_hit  = (base_e != '0)
                    && ((i_instruction & base_mask) == base_e[32:1]);

    always_comb begin
        if (is_sys) begin
            if (sys_hit) begin
                action = sys_e[0] ? pif_pkg::ACT_TRAP : pif_pkg::ACT_KEEP;
            end else begin
                action = pif_pkg::ACT_FILTER;
            end
        end else begin
            if (base_hit) begin
                action = base_e[0] ? pif_pkg::ACT_TRAP : pif_pkg::ACT_FILTER;
            end else begin
                action = pif_pkg::ACT_KEEP;
            end
        end
    end

    always_comb begin
        o_dec.is_system = is_sys;
        o_dec.action    = action;
        case (action)
            pif_pkg::ACT_TRAP:
                o_dec.replacement = pif_pkg::brk_word({pif_pkg::TRAP_TAG,
                                                       i_instruction[11:0]});
            pif_pkg::ACT_FILTER:
                o_dec.replacement = pif_pkg::brk_word(pif_pkg::FILTER_IMM);
            default:
                o_dec.replacement = i_instruction;
        endcase
    end

endmodule

### hw/rtl/pif_counters.sv
// ----------------------------------------------------------------------------
// pif_counters
// Wrapping running counts of system and base words; gives the counts that
// include the word now being decoded.
// ----------------------------------------------------------------------------
module pif_counters (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic                            i_is_system,
    output logic [pif_pkg::COUNT_OUT_W-1:0] o_sys_count,
    output logic [pif_pkg::COUNT_OUT_W-1:0] o_base_count
);

    logic [pif_pkg::COUNT_W-1:0] r_sys_cnt;
    logic [pif_pkg::COUNT_W-1:0] r_base_cnt;
    logic [pif_pkg::COUNT_W-1:0] n_sys_cnt;
    logic [pif_pkg::COUNT_W-1:0] n_base_cnt;

    assign n_sys_cnt  = r_sys_cnt  + pif_pkg::COUNT_W'(i_is_system);
    assign n_base_cnt = r_base_cnt + pif_pkg::COUNT_W'(!i_is_system);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_cnt  <= '0;
            r_base_cnt <= '0;
        end else if (i_advance) begin
            r_sys_cnt  <= n_sys_cnt;
            r_base_cnt <= n_base_cnt;
        end
    end

    assign o_sys_count  = pif_pkg::COUNT_OUT_W'(n_sys_cnt);
    assign o_base_count = pif_pkg::COUNT_OUT_W'(n_base_cnt);

`ifndef NO_ASSERTIONS
    a_sys_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_is_system |=>
            r_sys_cnt == $past(r_sys_cnt) + 1'b1 && $stable(r_base_cnt))
        else $error("system count did not step alone");

    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && !i_is_system |=>
            r_base_cnt == $past(r_base_cnt) + 1'b1 && $stable(r_sys_cnt))
        else $error("base count did not step alone");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_sys_cnt) && $stable(r_base_cnt))
        else $error("counts moved without a word");
`endif

endmodule

### hw/rtl/privileged_instruction_filter_core.sv
// ----------------------------------------------------------------------------
// privileged_instruction_filter_core
// Streams instruction words through a class test and ROM check and returns
// keep/trap/filter with the BRK replacement and running class counts.
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one instruction word per transaction, tlast marks the
//   final word of a section. master side returns exactly one result per word,
//   in order, with tlast echoing the input tlast.
//   path: an accepted word is held in the input register, decoded, and its
//   result is held in the result register: two register stages.
//   throughput: one word per cycle unless the receiver stalls; the decode
//   is a lookup in both roms and a compare between the two registers.
//   reset clears both valid flags and the two counters; the roms are fixed.
//   when the receiver stalls the result register holds, the input register
//   still fills, and o_s_tready drops only once both stages are full.
//   counts include the word they come with and run on across sections.
// ----------------------------------------------------------------------------
module privileged_instruction_filter_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,    // [31:0] instruction
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [135:0] o_m_tdata,    // [0] is_system, [2:1] action,
                                       // [34:3] replacement, [82:35] system_count,
                                       // [130:83] base_count, [135:131] zero
    output logic         o_m_tlast
);

    logic                            r_s1_valid;
    logic [31:0]                     r_s1_word;
    logic                            r_s1_last;
    logic                            r_o_valid;
    pif_pkg::t_decode                r_o_dec;
    logic [pif_pkg::COUNT_OUT_W-1:0] r_o_sys_cnt;
    logic [pif_pkg::COUNT_OUT_W-1:0] r_o_base_cnt;
    logic                            r_o_last;

    pif_pkg::t_decode                dec;
    logic [pif_pkg::COUNT_OUT_W-1:0] sys_cnt;
    logic [pif_pkg::COUNT_OUT_W-1:0] base_cnt;
    logic                            out_load;
    logic                            advance;
    logic                            in_load;

    assign out_load   = !r_o_valid || i_m_tready;
    assign advance    = r_s1_valid && out_load;
    assign o_s_tready = !r_s1_valid || out_load;
    assign in_load    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_s1_word <= i_s_tdata;
            r_s1_last <= i_s_tlast;
        end
    end

    pif_decode u_decode (
        .i_instruction (r_s1_word),
        .o_dec         (dec)
    );

    pif_counters u_counters (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_is_system  (dec.is_system),
        .o_sys_count  (sys_cnt),
        .o_base_count (base_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_dec      <= dec;
            r_o_sys_cnt  <= sys_cnt;
            r_o_base_cnt <= base_cnt;
            r_o_last     <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {5'd0, r_o_base_cnt, r_o_sys_cnt, r_o_dec.replacement,
                         r_o_dec.action, r_o_dec.is_system};

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_s1_valid && r_o_valid)
        else $error("input stalled with a free stage");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_o_dec.action == pif_pkg::ACT_KEEP
                   || r_o_dec.action == pif_pkg::ACT_TRAP
                   || r_o_dec.action == pif_pkg::ACT_FILTER)
        else $error("undefined action code");

    a_brk_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_dec.action != pif_pkg::ACT_KEEP |->
            r_o_dec.replacement[31:21] == pif_pkg::BRK_OPC
            && r_o_dec.replacement[4:0] == 5'd0)
        else $error("replacement is not a brk word");

    a_filter_imm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_dec.action == pif_pkg::ACT_FILTER |->
            r_o_dec.replacement[20:5] == pif_pkg::FILTER_IMM)
        else $error("filter word carries wrong immediate");
`endif

endmodule
